/* hdl/b32d_pkg.sv */
// ----------------------------------------------------------------------------
// b32d_pkg: shared types and constants of the base32 stream decoder
// Holds the result status codes, the character classes, the letter table and
// the struct types that pass between the decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package b32d_pkg;

   localparam int unsigned CharCountWidth = 18;
   localparam int unsigned ByteCountWidth = 16;
   localparam logic [CharCountWidth-1:0] CharCountMax = '1;

   // Dash character, consumed and skipped.
   localparam logic [7:0] CharDash = 8'h2D;

   typedef enum logic [1:0] {
      ST_DATA     = 2'd0,
      ST_DONE     = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CK_DIGIT = 2'd0,
      CK_DASH  = 2'd1,
      CK_TERM  = 2'd2
   } char_kind_type;

   typedef struct packed {
      char_kind_type kind;
      logic [4:0]    value;
   } char_info_type;

   typedef struct packed {
      status_type                status;
      logic [7:0]                data_byte;
      logic [ByteCountWidth-1:0] bytes_written;
      logic [CharCountWidth-1:0] chars_consumed;
   } rsp_beat_type;

   // Letter value, indexed by the low five bits of the code minus one
   // (A or a gives index 0). I and L read as 1, O as 0, Z as 2.
   function automatic logic [4:0] letter_value(input logic [4:0] idx);
      logic [4:0] v;
      case (idx)
         5'd0:    v = 5'd10;
         5'd1:    v = 5'd11;
         5'd2:    v = 5'd12;
         5'd3:    v = 5'd13;
         5'd4:    v = 5'd14;
         5'd5:    v = 5'd15;
         5'd6:    v = 5'd16;
         5'd7:    v = 5'd17;
         5'd8:    v = 5'd1;
         5'd9:    v = 5'd18;
         5'd10:   v = 5'd19;
         5'd11:   v = 5'd1;
         5'd12:   v = 5'd20;
         5'd13:   v = 5'd21;
         5'd14:   v = 5'd0;
         5'd15:   v = 5'd22;
         5'd16:   v = 5'd23;
         5'd17:   v = 5'd24;
         5'd18:   v = 5'd25;
         5'd19:   v = 5'd26;
         5'd20:   v = 5'd27;
         5'd21:   v = 5'd28;
         5'd22:   v = 5'd29;
         5'd23:   v = 5'd30;
         5'd24:   v = 5'd31;
         5'd25:   v = 5'd2;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

   // Bits already held before a digit, by position in the 8-digit group:
   // (5 * position) mod 8.
   function automatic logic [2:0] held_bits(input logic [2:0] pos);
      logic [2:0] h;
      case (pos)
         3'd0:    h = 3'd0;
         3'd1:    h = 3'd5;
         3'd2:    h = 3'd2;
         3'd3:    h = 3'd7;
         3'd4:    h = 3'd4;
         3'd5:    h = 3'd1;
         3'd6:    h = 3'd6;
         default: h = 3'd3;
      endcase
      return h;
   endfunction

endpackage

`default_nettype wire

/* hdl/b32d_char_decode.sv */
// ----------------------------------------------------------------------------
// b32d_char_decode: character classifier
// Sorts one raw character code into digit, dash or terminator and gives the
// five-bit digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_char_decode (
   input  wire logic [7:0]             char_code,
   output b32d_pkg::char_info_type     info
);

   logic [4:0] letter_idx;

   assign letter_idx = char_code[4:0] - 5'd1;

   always_comb begin
      info.kind  = b32d_pkg::CK_TERM;
      info.value = 5'd0;
      case (char_code) inside
         [8'h30:8'h39]: begin
            info.kind  = b32d_pkg::CK_DIGIT;
            info.value = {1'b0, char_code[3:0]};
         end
         [8'h41:8'h5A], [8'h61:8'h7A]: begin
            info.kind  = b32d_pkg::CK_DIGIT;
            info.value = b32d_pkg::letter_value(letter_idx);
         end
         b32d_pkg::CharDash: begin
            info.kind = b32d_pkg::CK_DASH;
         end
         default: begin
            info.kind = b32d_pkg::CK_TERM;
         end
      endcase
   end

endmodule

`default_nettype wire

/* hdl/b32d_core.sv */
// ----------------------------------------------------------------------------
// b32d_core: string state and byte assembly
// Holds the group position, pending bits and the byte and character counts,
// and forms at most one result beat for each accepted character.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire b32d_pkg::char_info_type info,
   input  wire logic [15:0]             capacity,
   output logic                         push,
   output b32d_pkg::rsp_beat_type       beat
);

   logic [2:0]  group_ff,   group_in;
   logic [11:0] pending_ff, pending_in;
   logic [b32d_pkg::ByteCountWidth-1:0] byte_count_ff, byte_count_in;
   logic [b32d_pkg::CharCountWidth-1:0] char_count_ff, char_count_in;

   logic [b32d_pkg::CharCountWidth-1:0] char_next;
   logic [b32d_pkg::ByteCountWidth-1:0] byte_next;
   logic [2:0]  held;
   logic [2:0]  shift;
   logic [11:0] acc;
   logic [11:0] acc_shifted;

   always_comb begin
      char_next   = (char_count_ff == b32d_pkg::CharCountMax) ?
                    char_count_ff : char_count_ff + 18'd1;
      byte_next   = byte_count_ff + 16'd1;
      held        = b32d_pkg::held_bits(group_ff);
      shift       = held - 3'd3;
      acc         = {pending_ff[6:0], info.value};
      acc_shifted = acc >> shift;

      group_in      = group_ff;
      pending_in    = pending_ff;
      byte_count_in = byte_count_ff;
      char_count_in = char_count_ff;

      push                = 1'b0;
      beat.status         = b32d_pkg::ST_DATA;
      beat.data_byte      = 8'd0;
      beat.bytes_written  = byte_count_ff;
      beat.chars_consumed = char_next;

      if (accept) begin
         char_count_in = char_next;
         unique case (info.kind)
            b32d_pkg::CK_DASH: begin
               char_count_in = char_next;
            end
            b32d_pkg::CK_DIGIT: begin
               group_in = group_ff + 3'd1;
               if (held < 3'd3) begin
                  // Fewer than eight bits so far, nothing to emit yet.
                  pending_in = acc;
               end else if (byte_count_ff >= capacity) begin
                  push          = 1'b1;
                  beat.status   = b32d_pkg::ST_OVERFLOW;
                  group_in      = 3'd0;
                  pending_in    = 12'd0;
                  byte_count_in = '0;
                  char_count_in = '0;
               end else begin
                  push               = 1'b1;
                  beat.data_byte     = acc_shifted[7:0];
                  beat.bytes_written = byte_next;
                  pending_in         = acc & ((12'd1 << shift) - 12'd1);
                  byte_count_in      = byte_next;
               end
            end
            b32d_pkg::CK_TERM: begin
               push          = 1'b1;
               beat.status   = b32d_pkg::ST_DONE;
               group_in      = 3'd0;
               pending_in    = 12'd0;
               byte_count_in = '0;
               char_count_in = '0;
            end
            default: begin
               char_count_in = char_next;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff      <= 3'd0;
         pending_ff    <= 12'd0;
         byte_count_ff <= '0;
         char_count_ff <= '0;
      end else begin
         group_ff      <= group_in;
         pending_ff    <= pending_in;
         byte_count_ff <= byte_count_in;
         char_count_ff <= char_count_in;
      end
   end

   // At most seven undelivered bits are ever carried between characters.
   a_pending_narrow: assert property (@(posedge clock) disable iff (reset)
      pending_ff[11:7] == 5'd0)
      else $error("pending bits exceed seven");

   // An end result clears the string state.
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (push && beat.status != b32d_pkg::ST_DATA) |=>
      (group_ff == 3'd0 && byte_count_ff == '0 && char_count_ff == '0))
      else $error("string state not cleared after end result");

   // A data byte advances the byte count by one.
   a_byte_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && beat.status == b32d_pkg::ST_DATA) |=>
      (byte_count_ff == $past(byte_count_ff) + 16'd1))
      else $error("byte count did not advance with data beat");

endmodule

`default_nettype wire

/* hdl/b32d_out_buf.sv */
// ----------------------------------------------------------------------------
// b32d_out_buf: result register with skid stage
// Keeps the result channel registered and lets the input side run on while
// one finished beat waits for the consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module b32d_out_buf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire b32d_pkg::rsp_beat_type push_beat,
   output logic                        room,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output b32d_pkg::rsp_beat_type      rsp_beat
);

   logic                   out_valid_ff,  out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   b32d_pkg::rsp_beat_type out_beat_ff,   out_beat_in;
   b32d_pkg::rsp_beat_type skid_beat_ff,  skid_beat_in;

   assign room      = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_beat_in   = out_beat_ff;
      skid_beat_in  = skid_beat_ff;
      if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_beat_in   = skid_beat_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_beat_in  = push_beat;
            out_valid_in = push;
         end
      end else if (push) begin
         // Output is stalled: park the new beat in the skid stage.
         skid_beat_in  = push_beat;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_beat_ff  <= out_beat_in;
      skid_beat_ff <= skid_beat_in;
   end

   // The skid stage is only ever filled behind a held output beat.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a beat with the output empty");

   // No new beat arrives while the skid stage is full.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("beat pushed into a full buffer");

endmodule

`default_nettype wire

/* hdl/base32_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// base32_stream_decoder_unit: Crockford-style base32 stream decoder
// Decodes one character per beat, emits each byte as soon as its eight bits
// are complete, and ends a string with a done or overflow beat.
//
//   Channel   Direction  Handshake         Payload
//   req_      in         valid / ready     char_code
//   rsp_      out        valid / ready     status, data_byte, bytes_written,
//                                          chars_consumed
//   csr_      in         write enable      out_capacity (no read-back)
//
// One character is accepted per cycle while the skid stage is empty; its result,
// if any, reaches the rsp_ channel from the output register or the skid stage.
// The lookup, shift and capacity compare of a character sit combinationally
// between the string state registers and the output register.
// A two-entry output buffer (register plus skid stage) keeps req_ready high
// while one result waits; req_ready drops only when both entries are full.
// Synchronous reset clears the string state and sets the capacity to its mask (65535 for 16 CAPACITY_BITS).
// ----------------------------------------------------------------------------
`default_nettype none

module base32_stream_decoder_unit #(
   parameter int unsigned CAPACITY_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_data_byte,
   output logic [15:0]      rsp_bytes_written,
   output logic [17:0]      rsp_chars_consumed,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   localparam int unsigned CapKeep = (CAPACITY_BITS < 16) ? CAPACITY_BITS : 16;
   localparam logic [15:0] CapMask = 16'((17'd1 << CapKeep) - 17'd1);

   logic [15:0]             capacity_ff, capacity_in;
   logic                    accept;
   logic                    push;
   logic                    room;
   b32d_pkg::char_info_type info;
   b32d_pkg::rsp_beat_type  push_beat;
   b32d_pkg::rsp_beat_type  rsp_beat;

   assign capacity_in = csr_wr_en ? (csr_wr_data & CapMask) : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CapMask;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign req_ready = room;
   assign accept    = req_valid && room;

   b32d_char_decode u_char_decode (
      .char_code (req_char_code),
      .info      (info)
   );

   b32d_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .info     (info),
      .capacity (capacity_ff),
      .push     (push),
      .beat     (push_beat)
   );

   b32d_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_beat (push_beat),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_status         = rsp_beat.status;
   assign rsp_data_byte      = rsp_beat.data_byte;
   assign rsp_bytes_written  = rsp_beat.bytes_written;
   assign rsp_chars_consumed = rsp_beat.chars_consumed;

endmodule

`default_nettype wire
